[sv/square_marker_id_decoder_core_assert.svh]
// ----------------------------------------------------------------------------
// Square marker ID decoder assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_MARKER_ID_DECODER_CORE_ASSERT_SVH
`define SQUARE_MARKER_ID_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define SMID_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("smid assertion failed");

// next-cycle implication
`define SMID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("smid assertion failed");

`endif

[sv/smid_pkg.sv]
// ----------------------------------------------------------------------------
// smid_pkg
// Types, constants and grid functions of the square marker ID decoder.
// ----------------------------------------------------------------------------
package smid_pkg;

  localparam int unsigned NumRot    = 4;
  localparam int unsigned NumRows   = 5;
  localparam int unsigned NumWords  = 4;
  localparam int unsigned GridBits  = 25;
  localparam int unsigned IdBits    = 10;

  typedef logic [GridBits-1:0] grid_t;
  typedef logic [4:0]          row_t;
  typedef logic [2:0]          rdist_t;
  typedef logic [4:0]          dist_t;
  typedef logic [1:0]          rot_t;
  typedef logic [IdBits-1:0]   id_t;

  typedef rdist_t [NumRows-1:0] row_dists_t;

  localparam row_t RowWords [NumWords] = '{5'h09, 5'h1D, 5'h12, 5'h0E};

  localparam dist_t BorderFailDist = 5'd25;

  typedef struct packed {
    logic                      border_fail;
    grid_t                     grid;
    row_dists_t [NumRot-1:0]   rdist;
  } s1_t;

  typedef struct packed {
    logic                 border_fail;
    grid_t                grid;
    dist_t [NumRot-1:0]   sum;
  } s2_t;

  function automatic grid_t turn_cw(input grid_t g);
    grid_t o;
    o = '0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        o[5*i+j] = g[5*(4-j)+i];
      end
    end
    return o;
  endfunction

  function automatic rdist_t row_distance(input row_t row);
    rdist_t best;
    rdist_t cnt;
    row_t   x;
    best = 3'd5;
    for (int w = 0; w < NumWords; w++) begin
      x   = row ^ RowWords[w];
      cnt = '0;
      for (int k = 0; k < 5; k++) begin
        cnt = cnt + {2'b00, x[k]};
      end
      if (cnt < best) best = cnt;
    end
    return best;
  endfunction

  function automatic id_t grid_id(input grid_t g);
    id_t v;
    v = '0;
    for (int r = 0; r < 5; r++) begin
      v[9-2*r] = g[5*r+1];
      v[8-2*r] = g[5*r+4];
    end
    return v;
  endfunction

endpackage

[sv/smid_dist.sv]
// ----------------------------------------------------------------------------
// smid_dist
// Stage 1: border check and per-row distances for all four rotations.
// ----------------------------------------------------------------------------
module smid_dist import smid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [23:0] border_cells_i,
  input  grid_t       code_cells_i,
  output logic        valid_o,
  input  logic        ready_i,
  output s1_t         data_o
);

  logic  valid_q;
  s1_t   data_d, data_q;
  grid_t rot_grid [NumRot];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    rot_grid[0] = code_cells_i;
    for (int k = 1; k < NumRot; k++) begin
      rot_grid[k] = turn_cw(rot_grid[k-1]);
    end
    data_d.border_fail = |border_cells_i;
    data_d.grid        = code_cells_i;
    for (int k = 0; k < NumRot; k++) begin
      for (int r = 0; r < NumRows; r++) begin
        data_d.rdist[k][r] = row_distance(rot_grid[k][5*r +: 5]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/smid_sum.sv]
// ----------------------------------------------------------------------------
// smid_sum
// Stage 2: sum the five row distances of each rotation.
// ----------------------------------------------------------------------------
module smid_sum import smid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s1_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s2_t  data_o
);

  logic valid_q;
  s2_t  data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.border_fail = data_i.border_fail;
    data_d.grid        = data_i.grid;
    for (int k = 0; k < NumRot; k++) begin
      data_d.sum[k] = '0;
      for (int r = 0; r < NumRows; r++) begin
        data_d.sum[k] = data_d.sum[k] + {2'b00, data_i.rdist[k][r]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/smid_pick.sv]
// ----------------------------------------------------------------------------
// smid_pick
// Stage 3: choose the first rotation with the least sum and read the ID.
// ----------------------------------------------------------------------------
module smid_pick import smid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  s2_t   data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output logic  is_marker_o,
  output id_t   marker_id_o,
  output rot_t  rotation_o,
  output dist_t best_distance_o
);

  logic  valid_q;
  logic  is_marker_d, is_marker_q;
  id_t   marker_id_d, marker_id_q;
  rot_t  rotation_d, rotation_q;
  dist_t best_d, best_q;
  dist_t best;
  rot_t  best_rot;
  grid_t rot_grid [NumRot];

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    rot_grid[0] = data_i.grid;
    for (int k = 1; k < NumRot; k++) begin
      rot_grid[k] = turn_cw(rot_grid[k-1]);
    end
    best     = data_i.sum[0];
    best_rot = '0;
    for (int k = 1; k < NumRot; k++) begin
      if (data_i.sum[k] < best) begin
        best     = data_i.sum[k];
        best_rot = rot_t'(k);
      end
    end
    if (data_i.border_fail) begin
      is_marker_d = 1'b0;
      marker_id_d = '0;
      rotation_d  = '0;
      best_d      = BorderFailDist;
    end else begin
      is_marker_d = (best == '0);
      marker_id_d = (best == '0) ? grid_id(rot_grid[best_rot]) : '0;
      rotation_d  = best_rot;
      best_d      = best;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      is_marker_q <= is_marker_d;
      marker_id_q <= marker_id_d;
      rotation_q  <= rotation_d;
      best_q      <= best_d;
    end
  end

  assign valid_o         = valid_q;
  assign is_marker_o     = is_marker_q;
  assign marker_id_o     = marker_id_q;
  assign rotation_o      = rotation_q;
  assign best_distance_o = best_q;

endmodule

[sv/square_marker_id_decoder_core.sv]
// ----------------------------------------------------------------------------
// square_marker_id_decoder_core
// Decodes a binarized 7x7 square marker into a 10-bit ID and rotation.
// ----------------------------------------------------------------------------
// Three register stages (row distances, per-rotation sums, best-rotation pick
// with output register) take one item per cycle while the output is not
// stalled; an item passes the distance, sum and pick registers in that order
// before its result reaches the outputs. Each stage holds its item under
// stall and takes a new one as soon as it is empty or its item moves on, so
// bubbles collapse behind a stalled output.
`include "square_marker_id_decoder_core_assert.svh"

module square_marker_id_decoder_core import smid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] border_cells_i,
  input  logic [24:0] code_cells_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_marker_o,
  output logic [9:0]  marker_id_o,
  output logic [1:0]  rotation_o,
  output logic [4:0]  best_distance_o
);

  logic s1_ready, s1_valid;
  logic s2_ready, s2_valid;
  logic s3_ready;
  s1_t  s1_data;
  s2_t  s2_data;

  smid_dist u_dist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_valid_i),
    .ready_o        (s1_ready),
    .border_cells_i (border_cells_i),
    .code_cells_i   (code_cells_i),
    .valid_o        (s1_valid),
    .ready_i        (s2_ready),
    .data_o         (s1_data)
  );

  smid_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s3_ready),
    .data_o  (s2_data)
  );

  smid_pick u_pick (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (s2_valid),
    .ready_o         (s3_ready),
    .data_i          (s2_data),
    .valid_o         (out_valid_o),
    .ready_i         (!out_stall_i),
    .is_marker_o     (is_marker_o),
    .marker_id_o     (marker_id_o),
    .rotation_o      (rotation_o),
    .best_distance_o (best_distance_o)
  );

  assign in_stall_o = !s1_ready;

  `SMID_ASSERT_SAME(a_marker_zero_dist, clk_i, rst_ni, out_valid_o && is_marker_o, best_distance_o == '0)
  `SMID_ASSERT_SAME(a_reject_zero_id, clk_i, rst_ni, out_valid_o && !is_marker_o, marker_id_o == '0)
  `SMID_ASSERT_SAME(a_rot_not_border, clk_i, rst_ni, out_valid_o && (rotation_o != '0), best_distance_o != BorderFailDist)
  `SMID_ASSERT_NEXT(a_drain_frees_in, clk_i, rst_ni, !out_valid_o && !s2_valid && !s1_valid, !in_stall_o)

endmodule
